### design/utf8_heading_slug_filter_core_assert.svh
`ifndef UTF8_HEADING_SLUG_FILTER_CORE_ASSERT_SVH
`define UTF8_HEADING_SLUG_FILTER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked only outside reset.
`define USHF_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ushf assertion failed");
// Checked at every edge, reset included.
`define USHF_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("ushf assertion failed");
`else
`define USHF_ASSERT(label, prop)
`define USHF_ASSERT_ALWAYS(label, prop)
`endif

`endif

### design/ushf_pkg.sv
package ushf_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW = 21;
  localparam int unsigned RunDepth = 4;
  localparam int unsigned HeldDepth = 3;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [CpW-1:0] cp_t;

  // ASCII characters
  localparam byte_t ChTab = 8'h09;
  localparam byte_t ChSpace = 8'h20;
  localparam byte_t ChDash = 8'h2D;
  localparam byte_t ChUnderscore = 8'h5F;
  localparam byte_t ChDigit0 = 8'h30;
  localparam byte_t ChDigit9 = 8'h39;
  localparam byte_t ChUpperA = 8'h41;
  localparam byte_t ChUpperZ = 8'h5A;
  localparam byte_t ChLowerA = 8'h61;
  localparam byte_t ChLowerZ = 8'h7A;
  localparam byte_t CaseBit = 8'h20;
  localparam byte_t NullByte = 8'h00;

  // lead byte classes
  localparam byte_t Lead2Lo = 8'hC2;
  localparam byte_t Lead2Hi = 8'hDF;
  localparam byte_t Lead3Lo = 8'hE0;
  localparam byte_t Lead3Hi = 8'hEF;
  localparam byte_t Lead4Lo = 8'hF0;
  localparam byte_t Lead4Hi = 8'hF4;

  // well-formedness limits
  localparam cp_t CpMin2 = 21'h000080;
  localparam cp_t CpMin3 = 21'h000800;
  localparam cp_t CpMin4 = 21'h010000;
  localparam cp_t CpMax = 21'h10FFFF;
  localparam cp_t SurrLo = 21'h00D800;
  localparam cp_t SurrHi = 21'h00DFFF;

  // dropped symbol and punctuation ranges
  localparam cp_t CpReplacement = 21'h00FFFD;
  localparam cp_t Sym0Lo = 21'h0000A0;
  localparam cp_t Sym0Hi = 21'h0000BF;
  localparam cp_t Sym1Lo = 21'h002000;
  localparam cp_t Sym1Hi = 21'h002BFF;
  localparam cp_t Sym2Lo = 21'h002E00;
  localparam cp_t Sym2Hi = 21'h002E7F;
  localparam cp_t Sym3Lo = 21'h003000;
  localparam cp_t Sym3Hi = 21'h00303F;
  localparam cp_t Sym4Lo = 21'h00FF01;
  localparam cp_t Sym4Hi = 21'h00FF0F;
  localparam cp_t Sym5Lo = 21'h00FF1A;
  localparam cp_t Sym5Hi = 21'h00FF20;
  localparam cp_t Sym6Lo = 21'h00FF3B;
  localparam cp_t Sym6Hi = 21'h00FF40;
  localparam cp_t Sym7Lo = 21'h00FF5B;
  localparam cp_t Sym7Hi = 21'h00FF65;

  typedef struct packed {
    logic  keep;
    byte_t ch;
  } ascii_map_t;

  function automatic ascii_map_t ascii_slug(input byte_t b);
    ascii_map_t m;
    m.keep = 1'b1;
    m.ch = b;
    if (b inside {[ChUpperA:ChUpperZ]}) begin
      m.ch = b | CaseBit;
    end else if (b == ChSpace || b == ChTab) begin
      m.ch = ChDash;
    end else if (!(b inside {[ChLowerA:ChLowerZ], [ChDigit0:ChDigit9], ChDash,
                             ChUnderscore})) begin
      m.keep = 1'b0;
    end
    return m;
  endfunction

  function automatic logic skip_symbol(input cp_t cp);
    return (cp == CpReplacement) ||
           (cp inside {[Sym0Lo:Sym0Hi], [Sym1Lo:Sym1Hi], [Sym2Lo:Sym2Hi], [Sym3Lo:Sym3Hi],
                       [Sym4Lo:Sym4Hi], [Sym5Lo:Sym5Hi], [Sym6Lo:Sym6Hi], [Sym7Lo:Sym7Hi]});
  endfunction

  // cont is the number of continuation bytes of the sequence
  function automatic logic well_formed(input cp_t cp, input logic [1:0] cont);
    logic ok;
    case (cont)
      2'd1: ok = (cp >= CpMin2);
      2'd2: ok = (cp >= CpMin3) && !(cp inside {[SurrLo:SurrHi]});
      default: ok = (cp >= CpMin4) && (cp <= CpMax);
    endcase
    return ok;
  endfunction

endpackage

### design/ushf_in_if.sv
interface ushf_in_if import ushf_pkg::*;;
  logic  valid;
  logic  ready;
  byte_t in_byte;
  logic  text_end;

  modport source (output valid, output in_byte, output text_end, input ready);
  modport sink (input valid, input in_byte, input text_end, output ready);
endinterface

### design/ushf_out_if.sv
interface ushf_out_if import ushf_pkg::*;;
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  byte_valid;
  logic  run_last;
  logic  slug_end;

  modport source (output valid, output out_byte, output byte_valid, output run_last,
                  output slug_end, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input run_last,
                input slug_end, output ready);
endinterface

### design/utf8_heading_slug_filter_core.sv
// Heading slug filter: takes heading text as UTF-8 bytes on in_i and gives the anchor slug
// bytes on out_o, one slug word per handshake, each marked with run_last on the final word
// an input byte causes and slug_end on the final word of the slug. An input byte is decoded
// in the cycle it is accepted and its words (zero to four) land in a run register that
// drains one word per cycle while out_o is ready; a byte that yields no word leaves the run
// empty. The run register sets the rate: a new byte is taken while the run is empty or its
// last word leaves, so ASCII text flows at one byte per cycle while out_o is ready and a
// completed multibyte sequence holds input until its last word leaves. A heading whose final
// byte yields nothing still gives one word with byte_valid low.
`include "utf8_heading_slug_filter_core_assert.svh"

module utf8_heading_slug_filter_core import ushf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  ushf_in_if.sink           in_i,
  ushf_out_if.source        out_o
);

  // open sequence state
  logic [1:0] exp_q, exp_d;
  logic [1:0] held_q, held_d;
  cp_t        acc_q, acc_d;
  byte_t      hb_q [HeldDepth];
  logic       hb_wr;
  logic [1:0] hb_wr_idx;

  // run register
  logic       run_valid_q;
  logic [1:0] run_idx_q;
  logic [1:0] run_last_idx_q;
  logic       run_end_q;
  logic       run_fill_q;
  byte_t      run_bytes_q [RunDepth];
  byte_t      run_bytes_d [RunDepth];

  logic       in_fire, out_fire, run_done;
  logic       is_cont, filler;
  logic [2:0] emit_n;
  cp_t        acc_shift;
  byte_t      b;
  ascii_map_t amap;

  assign run_done = (run_idx_q == run_last_idx_q);
  assign out_fire = run_valid_q & out_o.ready;
  assign in_i.ready = !run_valid_q || (out_o.ready && run_done);
  assign in_fire = in_i.valid & in_i.ready;

  assign b = in_i.in_byte;
  assign is_cont = (exp_q != 2'd0) && (b[7:6] == 2'b10);
  assign acc_shift = {acc_q[CpW-7:0], b[5:0]};
  assign amap = ascii_slug(b);

  always_comb begin
    exp_d = exp_q;
    held_d = held_q;
    acc_d = acc_q;
    hb_wr = 1'b0;
    hb_wr_idx = held_q;
    emit_n = 3'd0;
    filler = 1'b0;
    for (int i = 0; i < HeldDepth; i++) begin
      run_bytes_d[i] = hb_q[i];
    end
    run_bytes_d[RunDepth-1] = b;

    if (is_cont) begin
      acc_d = acc_shift;
      if (held_q >= exp_q) begin
        // sequence complete: emit held bytes plus this one if well-formed and not a dropped symbol
        if (well_formed(acc_shift, exp_q) && !skip_symbol(acc_shift)) begin
          emit_n = {1'b0, held_q} + 3'd1;
          run_bytes_d[held_q] = b;
        end
        exp_d = 2'd0;
        held_d = 2'd0;
        acc_d = '0;
      end else if (held_q != 2'd3) begin
        hb_wr = 1'b1;
        held_d = held_q + 2'd1;
      end else begin
        exp_d = 2'd0;
        held_d = 2'd0;
        acc_d = '0;
      end
    end else begin
      // drop any open sequence, then treat as a fresh byte
      exp_d = 2'd0;
      held_d = 2'd0;
      acc_d = '0;
      if (!b[7]) begin
        if (amap.keep) begin
          emit_n = 3'd1;
          run_bytes_d[0] = amap.ch;
        end
      end else if (b inside {[Lead2Lo:Lead2Hi]}) begin
        exp_d = 2'd1;
        acc_d = cp_t'(b[4:0]);
        held_d = 2'd1;
        hb_wr = 1'b1;
        hb_wr_idx = 2'd0;
      end else if (b inside {[Lead3Lo:Lead3Hi]}) begin
        exp_d = 2'd2;
        acc_d = cp_t'(b[3:0]);
        held_d = 2'd1;
        hb_wr = 1'b1;
        hb_wr_idx = 2'd0;
      end else if (b inside {[Lead4Lo:Lead4Hi]}) begin
        exp_d = 2'd3;
        acc_d = cp_t'(b[2:0]);
        held_d = 2'd1;
        hb_wr = 1'b1;
        hb_wr_idx = 2'd0;
      end
    end

    if (in_i.text_end) begin
      // truncated sequence at the end is dropped
      exp_d = 2'd0;
      held_d = 2'd0;
      acc_d = '0;
      if (emit_n == 3'd0) begin
        emit_n = 3'd1;
        filler = 1'b1;
        run_bytes_d[0] = NullByte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= 2'd0;
      held_q <= 2'd0;
      acc_q <= '0;
    end else if (in_fire) begin
      exp_q <= exp_d;
      held_q <= held_d;
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && hb_wr) begin
      hb_q[hb_wr_idx] <= b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
      run_idx_q <= 2'd0;
      run_last_idx_q <= 2'd0;
      run_end_q <= 1'b0;
      run_fill_q <= 1'b0;
    end else if (in_fire) begin
      run_valid_q <= (emit_n != 3'd0);
      run_idx_q <= 2'd0;
      run_last_idx_q <= 2'(emit_n - 3'd1);
      run_end_q <= in_i.text_end;
      run_fill_q <= filler;
    end else if (out_fire) begin
      if (run_done) begin
        run_valid_q <= 1'b0;
      end else begin
        run_idx_q <= run_idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      run_bytes_q <= run_bytes_d;
    end
  end

  assign out_o.valid = run_valid_q;
  assign out_o.out_byte = run_bytes_q[run_idx_q];
  assign out_o.byte_valid = !run_fill_q;
  assign out_o.run_last = run_done;
  assign out_o.slug_end = run_end_q & run_done;

  `USHF_ASSERT(a_idx_in_run, run_valid_q |-> run_idx_q <= run_last_idx_q)
  `USHF_ASSERT(a_fill_only_at_end,
               (run_valid_q && run_fill_q) |-> (run_end_q && run_last_idx_q == 2'd0))
  `USHF_ASSERT(a_end_clears_seq,
               (in_fire && in_i.text_end) |=> (exp_q == 2'd0 && held_q == 2'd0))
  `USHF_ASSERT_ALWAYS(a_held_needs_open, (exp_q == 2'd0) |-> (held_q == 2'd0))

endmodule
